@@ rtl/core/pla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pla_pkg;

    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int ELEMENT_W = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOCATE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        ADDR_LO    = 2'd0,
        ADDR_LO_M1 = 2'd1,
        ADDR_HI    = 2'd2
    } addr_sel_t;

    typedef enum logic [1:0] {
        WDATA_RDATA = 2'd0,
        WDATA_HOLD  = 2'd1,
        WDATA_VALUE = 2'd2
    } wdata_sel_t;

    typedef struct packed {
        logic       accept;
        logic       init;
        logic       rd_en;
        addr_sel_t  rd_addr_sel;
        logic       wr_en;
        addr_sel_t  wr_addr_sel;
        wdata_sel_t wr_data_sel;
        logic       lo_inc;
        logic       lo_dec;
        logic       hi_dec;
        logic       hold_load;
        logic       get_capture;
        logic       loc_hit;
        logic       used_inc;
        logic       used_dec;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              go;
        logic              ins_done;
        logic              lo_lt_used;
        logic              lo_lt_hi;
        logic              match;
        logic              out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pla_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pla_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pla_ctrl
    import pla_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [15:0] {
        ST_IDLE    = 16'b0000_0000_0000_0001,
        ST_CHECK   = 16'b0000_0000_0000_0010,
        ST_INS_RD  = 16'b0000_0000_0000_0100,
        ST_INS_WR  = 16'b0000_0000_0000_1000,
        ST_INS_PUT = 16'b0000_0000_0001_0000,
        ST_DEL_RD  = 16'b0000_0000_0010_0000,
        ST_DEL_WR  = 16'b0000_0000_0100_0000,
        ST_GET_RD  = 16'b0000_0000_1000_0000,
        ST_GET_CAP = 16'b0000_0001_0000_0000,
        ST_LOC_RD  = 16'b0000_0010_0000_0000,
        ST_LOC_CMP = 16'b0000_0100_0000_0000,
        ST_REV_RA  = 16'b0000_1000_0000_0000,
        ST_REV_RB  = 16'b0001_0000_0000_0000,
        ST_REV_WA  = 16'b0010_0000_0000_0000,
        ST_REV_WB  = 16'b0100_0000_0000_0000,
        ST_FINISH  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.init = 1'b1;
                if (!stat.go)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    priority case (stat.kind)
                        KIND_INSERT:  state_next = ST_INS_RD;
                        KIND_DELETE:  state_next = ST_DEL_RD;
                        KIND_GET:     state_next = ST_GET_RD;
                        KIND_LOCATE:  state_next = ST_LOC_RD;
                        KIND_REVERSE: state_next = ST_REV_RA;
                        default:      state_next = ST_FINISH;
                    endcase
                end
            end
            ST_INS_RD:
            begin
                if (stat.ins_done)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = ADDR_LO_M1;
                    state_next      = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = ADDR_LO;
                cmd.wr_data_sel = WDATA_RDATA;
                cmd.lo_dec      = 1'b1;
                state_next      = ST_INS_RD;
            end
            ST_INS_PUT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = ADDR_LO;
                cmd.wr_data_sel = WDATA_VALUE;
                cmd.used_inc    = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_DEL_RD:
            begin
                if (!stat.lo_lt_used)
                begin
                    cmd.used_dec = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = ADDR_LO;
                    state_next      = ST_DEL_WR;
                end
            end
            ST_DEL_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = ADDR_LO_M1;
                cmd.wr_data_sel = WDATA_RDATA;
                cmd.lo_inc      = 1'b1;
                state_next      = ST_DEL_RD;
            end
            ST_GET_RD:
            begin
                cmd.rd_en       = 1'b1;
                cmd.rd_addr_sel = ADDR_LO;
                state_next      = ST_GET_CAP;
            end
            ST_GET_CAP:
            begin
                cmd.get_capture = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_LOC_RD:
            begin
                if (!stat.lo_lt_used)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = ADDR_LO;
                    state_next      = ST_LOC_CMP;
                end
            end
            ST_LOC_CMP:
            begin
                if (stat.match)
                begin
                    cmd.loc_hit = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.lo_inc = 1'b1;
                    state_next = ST_LOC_RD;
                end
            end
            ST_REV_RA:
            begin
                if (!stat.lo_lt_hi)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = ADDR_LO;
                    state_next      = ST_REV_RB;
                end
            end
            ST_REV_RB:
            begin
                cmd.hold_load   = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_addr_sel = ADDR_HI;
                state_next      = ST_REV_WA;
            end
            ST_REV_WA:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = ADDR_LO;
                cmd.wr_data_sel = WDATA_RDATA;
                state_next      = ST_REV_WB;
            end
            ST_REV_WB:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = ADDR_HI;
                cmd.wr_data_sel = WDATA_HOLD;
                cmd.lo_inc      = 1'b1;
                cmd.hi_dec      = 1'b1;
                state_next      = ST_REV_RA;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pla_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pla_datapath
    import pla_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int DATA_W   = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [KIND_W-1:0]                in_kind,
    input  wire logic [$clog2(CAPACITY+1)-1:0]    in_position,
    input  wire logic [VALUE_W-1:0]               in_value,
    input  wire dp_cmd_t                          cmd,
    output dp_stat_t                              stat,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [STATUS_W-1:0]                   out_status,
    output logic [ELEMENT_W-1:0]                  out_element,
    output logic [$clog2(CAPACITY+1):0]           out_found_at,
    output logic [$clog2(CAPACITY+1)-1:0]         out_count
);

    localparam int POS_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int FOUND_W = POS_W + 1;
    localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

    logic [KIND_W-1:0]    kind_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [DATA_W-1:0]    val_reg;
    logic [DATA_W-1:0]    val_wide;
    logic [POS_W-1:0]     used_reg;
    logic [POS_W-1:0]     lo_reg;
    logic [POS_W-1:0]     hi_reg;
    logic [DATA_W-1:0]    hold_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [ELEMENT_W-1:0] res_element_reg;
    logic [FOUND_W-1:0]   res_found_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ELEMENT_W-1:0] out_element_reg;
    logic [FOUND_W-1:0]   out_found_reg;
    logic [POS_W-1:0]     out_count_reg;

    logic [STATUS_W-1:0]  chk_status;
    logic                 chk_go;
    logic [POS_W:0]       used_p1;
    logic                 pos_zero;
    logic [POS_W-1:0]     lo_m1;
    logic [POS_W-1:0]     pos_m1;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [DATA_W-1:0]    ram_rdata;
    logic [ELEMENT_W-1:0] rdata_elem;

    generate
        if (DATA_W >= VALUE_W)
        begin : g_wide
            assign val_wide   = DATA_W'($signed(in_value));
            assign rdata_elem = ram_rdata[ELEMENT_W-1:0];
        end
        else
        begin : g_narrow
            assign val_wide   = in_value[DATA_W-1:0];
            assign rdata_elem = ELEMENT_W'(ram_rdata);
        end
    endgenerate

    assign used_p1  = {1'b0, used_reg} + 1'b1;
    assign pos_zero = (pos_reg == '0);
    assign lo_m1    = lo_reg - 1'b1;
    assign pos_m1   = pos_reg - 1'b1;

    always_comb
    begin
        chk_status = STATUS_OK;
        chk_go     = 1'b0;
        priority case (kind_reg)
            KIND_INSERT:
            begin
                if (used_reg == CAP_COUNT)
                begin
                    chk_status = STATUS_FULL;
                end
                else if (pos_zero || ({1'b0, pos_reg} > used_p1))
                begin
                    chk_status = STATUS_BAD_POS;
                end
                else
                begin
                    chk_go = 1'b1;
                end
            end
            KIND_DELETE, KIND_GET:
            begin
                if (used_reg == '0)
                begin
                    chk_status = STATUS_EMPTY;
                end
                else if (pos_zero || (pos_reg > used_reg))
                begin
                    chk_status = STATUS_BAD_POS;
                end
                else
                begin
                    chk_go = 1'b1;
                end
            end
            KIND_LOCATE:
            begin
                chk_status = STATUS_NOT_FOUND;
                chk_go     = (used_reg != '0);
            end
            KIND_REVERSE:
            begin
                chk_go = (used_reg > POS_W'(1));
            end
            default:
            begin
                chk_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_addr_sel)
            ADDR_LO_M1: rd_addr = lo_m1[IDX_W-1:0];
            ADDR_HI:    rd_addr = hi_reg[IDX_W-1:0];
            default:    rd_addr = lo_reg[IDX_W-1:0];
        endcase
        unique case (cmd.wr_addr_sel)
            ADDR_LO_M1: wr_addr = lo_m1[IDX_W-1:0];
            ADDR_HI:    wr_addr = hi_reg[IDX_W-1:0];
            default:    wr_addr = lo_reg[IDX_W-1:0];
        endcase
        unique case (cmd.wr_data_sel)
            WDATA_HOLD:  wr_data = hold_reg;
            WDATA_VALUE: wr_data = val_reg;
            default:     wr_data = ram_rdata;
        endcase
    end

    pla_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.used_inc)
            begin
                used_reg <= used_reg + 1'b1;
            end
            else if (cmd.used_dec)
            begin
                used_reg <= used_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            pos_reg  <= in_position;
            val_reg  <= val_wide;
        end
        if (cmd.init)
        begin
            res_status_reg  <= chk_status;
            res_element_reg <= '0;
            res_found_reg   <= (kind_reg == KIND_LOCATE) ? {FOUND_W{1'b1}} : '0;
            hi_reg          <= used_reg - 1'b1;
            priority case (kind_reg)
                KIND_INSERT: lo_reg <= used_reg;
                KIND_DELETE: lo_reg <= pos_reg;
                KIND_GET:    lo_reg <= pos_m1;
                default:     lo_reg <= '0;
            endcase
        end
        else
        begin
            if (cmd.lo_inc)
            begin
                lo_reg <= lo_reg + 1'b1;
            end
            else if (cmd.lo_dec)
            begin
                lo_reg <= lo_m1;
            end
            if (cmd.hi_dec)
            begin
                hi_reg <= hi_reg - 1'b1;
            end
        end
        if (cmd.hold_load)
        begin
            hold_reg <= ram_rdata;
        end
        if (cmd.get_capture)
        begin
            res_element_reg <= rdata_elem;
        end
        if (cmd.loc_hit)
        begin
            res_status_reg <= STATUS_OK;
            res_found_reg  <= {1'b0, lo_reg + 1'b1};
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_element_reg <= res_element_reg;
            out_found_reg   <= res_found_reg;
            out_count_reg   <= used_reg;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.go         = chk_go;
    assign stat.ins_done   = (lo_reg == pos_m1);
    assign stat.lo_lt_used = (lo_reg < used_reg);
    assign stat.lo_lt_hi   = (lo_reg < hi_reg);
    assign stat.match      = (ram_rdata == val_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_element  = out_element_reg;
    assign out_found_at = out_found_reg;
    assign out_count    = out_count_reg;

endmodule

`default_nettype wire

@@ rtl/core/positional_array_list.sv @@
// Ordered list of up to CAPACITY signed words, positions counted from 1, kept in one
// simple dual-port RAM with registered read. Each command on the slave stream
// (tuser = kind: insert, delete, get, locate, reverse) yields exactly one result
// transaction on the master stream carrying status, element, found position and the
// new element count; the list takes one command at a time while the previous result
// may still wait at the output register. Every RAM move is a read followed by a
// write: insert shifts the elements from position p to the end one slot back, delete
// shifts those after p one slot forward, get reads the slot at p, locate
// reads from the front until a hit or the end, and reverse swaps pairs from both ends
// inward. An error, an unknown kind, a locate on an empty list or a reverse of fewer
// than two elements touches no RAM. A command occupies the block until its result is
// loaded into the output register, waiting for that register to free. An insert into
// a full list is refused with a full status rather than growing the store.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list
    import pla_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int DATA_W   = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // position, value
    input  wire logic [((($clog2(CAPACITY+1)) + 32 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind
    input  wire logic [2:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // element, found_at, count
    output logic [((32 + 2 * ($clog2(CAPACITY+1)) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status
    output logic [2:0] m_axis_tuser
);

    localparam int POS_W     = $clog2(CAPACITY + 1);
    localparam int FOUND_W   = POS_W + 1;
    localparam int OUT_USED  = ELEMENT_W + FOUND_W + POS_W;
    localparam int M_TDATA_W = ((OUT_USED + 7) / 8) * 8;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [STATUS_W-1:0]  out_status;
    logic [ELEMENT_W-1:0] out_element;
    logic [FOUND_W-1:0]   out_found_at;
    logic [POS_W-1:0]     out_count;

    pla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pla_datapath #(
        .CAPACITY (CAPACITY),
        .DATA_W   (DATA_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_kind      (s_axis_tuser),
        .in_position  (s_axis_tdata[POS_W-1:0]),
        .in_value     (s_axis_tdata[POS_W+VALUE_W-1:POS_W]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (out_status),
        .out_element  (out_element),
        .out_found_at (out_found_at),
        .out_count    (out_count)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = M_TDATA_W'({out_count, out_found_at, out_element});

endmodule

`default_nettype wire

@@ tb/sv/positional_array_list_tb.sv @@
`timescale 1ns / 1ps

module positional_array_list_tb;
    import pla_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int POS_W       = $clog2(CAPACITY + 1);
    localparam int S_DATA_W    = ((POS_W + 32 + 7) / 8) * 8;
    localparam int M_DATA_W    = ((32 + 2 * POS_W + 1 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_NEG1 = 32'hFFFF_FFFF;
    localparam logic [POS_W:0] NOT_LOCATED = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         element;
        logic [POS_W:0]      found_at;
        logic [POS_W-1:0]    count;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [2:0]          s_axis_tuser = KIND_INSERT;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [2:0]          m_axis_tuser;

    logic [31:0]   list_words [CAPACITY];
    int            list_len = 0;
    list_result_t  pending_results [$];
    list_result_t  oldest_result;
    bit            no_idle = 1'b0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    positional_array_list #(
        .CAPACITY(CAPACITY),
        .DATA_W  (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic list_result_t apply_list_cmd(input logic [2:0] kind,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [31:0] value);
        list_result_t r;
        int           p;
        int           j;
        logic [31:0]  t;
        r = '0;
        p = int'(pos);
        case (kind)
            KIND_INSERT:
            begin
                if (list_len >= CAPACITY)
                    r.status = STATUS_FULL;
                else if (p < 1 || p > list_len + 1)
                    r.status = STATUS_BAD_POS;
                else
                begin
                    for (j = list_len; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = value;
                    list_len++;
                end
            end
            KIND_DELETE:
            begin
                if (list_len < 1)
                    r.status = STATUS_EMPTY;
                else if (p < 1 || p > list_len)
                    r.status = STATUS_BAD_POS;
                else
                begin
                    for (j = p; j < list_len; j++)
                        list_words[j-1] = list_words[j];
                    list_len--;
                end
            end
            KIND_GET:
            begin
                if (list_len < 1)
                    r.status = STATUS_EMPTY;
                else if (p < 1 || p > list_len)
                    r.status = STATUS_BAD_POS;
                else
                    r.element = list_words[p-1];
            end
            KIND_LOCATE:
            begin
                r.status   = STATUS_NOT_FOUND;
                r.found_at = NOT_LOCATED;
                for (j = 0; j < list_len; j++)
                begin
                    if (list_words[j] == value)
                    begin
                        r.status   = STATUS_OK;
                        r.found_at = (POS_W+1)'(j + 1);
                        break;
                    end
                end
            end
            KIND_REVERSE:
            begin
                for (j = 0; j < list_len / 2; j++)
                begin
                    t                          = list_words[j];
                    list_words[j]              = list_words[list_len-1-j];
                    list_words[list_len-1-j]   = t;
                end
            end
            default:
                r.status = STATUS_OK;
        endcase
        r.count = POS_W'(list_len);
        return r;
    endfunction

    task automatic send_cmd(input logic [2:0] kind, input logic [POS_W-1:0] pos,
                            input logic [31:0] value);
        logic [S_DATA_W-1:0] word;
        word                 = '0;
        word[POS_W-1:0]      = pos;
        word[POS_W +: 32]    = value;
        while (!no_idle && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_list_cmd(kind, pos, value));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_NEG1;
            4, 5: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int span);
        if (span < 1 || $urandom_range(9) == 0)
            return POS_W'($urandom_range(CAPACITY));
        return POS_W'($urandom_range(span, 1));
    endfunction

    function automatic logic [31:0] pick_target();
        if (list_len > 0 && $urandom_range(3) != 0)
            return list_words[$urandom_range(list_len - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_list();
        send_cmd(KIND_DELETE, 1, '0);
        send_cmd(KIND_GET, 1, '0);
        send_cmd(KIND_LOCATE, 0, '0);
        send_cmd(KIND_REVERSE, 0, '0);
        send_cmd(KIND_INSERT, 0, WORD_MAX);
        send_cmd(KIND_INSERT, 2, WORD_MAX);
        send_cmd(KIND_UNUSED_LO, CAPACITY, WORD_NEG1);
        send_cmd(KIND_UNUSED_HI, 1, WORD_MIN);
    endtask

    task automatic test_edit_and_read();
        send_cmd(KIND_INSERT, 1, WORD_MIN);
        send_cmd(KIND_INSERT, 2, WORD_MAX);
        send_cmd(KIND_INSERT, 1, WORD_NEG1);
        send_cmd(KIND_INSERT, 2, '0);
        send_cmd(KIND_INSERT, 6, 32'h1234_5678);
        send_cmd(KIND_INSERT, 0, 32'h1234_5678);
        send_cmd(KIND_GET, 1, '0);
        send_cmd(KIND_GET, 4, '0);
        send_cmd(KIND_GET, 5, '0);
        send_cmd(KIND_GET, 0, '0);
        send_cmd(KIND_LOCATE, 0, WORD_MAX);
        send_cmd(KIND_LOCATE, 0, WORD_NEG1);
        send_cmd(KIND_LOCATE, 0, 32'd5);
        send_cmd(KIND_REVERSE, 0, '0);
        send_cmd(KIND_DELETE, 4, '0);
        send_cmd(KIND_DELETE, 0, '0);
        send_cmd(KIND_DELETE, 4, '0);
        send_cmd(KIND_REVERSE, 0, '0);
        send_cmd(KIND_DELETE, 1, '0);
        send_cmd(KIND_DELETE, 1, '0);
        send_cmd(KIND_REVERSE, 0, '0);
        send_cmd(KIND_DELETE, 1, '0);
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
            send_cmd(KIND_INSERT, POS_W'($urandom_range(list_len + 1, 1)), pick_value());
        send_cmd(KIND_INSERT, 1, pick_value());
        send_cmd(KIND_INSERT, CAPACITY, pick_value());
        send_cmd(KIND_GET, CAPACITY, '0);
        send_cmd(KIND_LOCATE, 0, list_words[CAPACITY-1]);
        send_cmd(KIND_LOCATE, 0, 32'hDEAD_BEEF);
        send_cmd(KIND_REVERSE, 0, '0);
        send_cmd(KIND_DELETE, CAPACITY, '0);
        while (list_len > 0)
            send_cmd(KIND_DELETE, POS_W'($urandom_range(list_len, 1)), '0);
    endtask

    task automatic test_random_walk(input int n_items);
        int          i;
        int          bias;
        int          ins_pct;
        int          del_pct;
        int          roll;
        logic [2:0]  kind;
        bias = 0;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                bias = $urandom_range(2);
            ins_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
            del_pct = (bias == 0) ? 10 : (bias == 1) ? 45 : 25;
            roll = $urandom_range(99);
            if (roll < 2)
                kind = KIND_UNUSED_LO + 3'($urandom_range(2));
            else
            begin
                roll = $urandom_range(99);
                if (roll < ins_pct)
                    kind = KIND_INSERT;
                else if (roll < ins_pct + del_pct)
                    kind = KIND_DELETE;
                else
                begin
                    case ($urandom_range(4))
                        0, 1: kind = KIND_GET;
                        2, 3: kind = KIND_LOCATE;
                        default: kind = KIND_REVERSE;
                    endcase
                end
            end
            case (kind)
                KIND_INSERT: send_cmd(kind, pick_position(list_len + 1), pick_value());
                KIND_DELETE, KIND_GET: send_cmd(kind, pick_position(list_len), $urandom);
                KIND_LOCATE: send_cmd(kind, POS_W'($urandom_range(CAPACITY)), pick_target());
                default: send_cmd(kind, POS_W'($urandom_range(CAPACITY)), $urandom);
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no command pending");
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_axis_tuser !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[31:0] !== oldest_result.element)
                begin
                    $error("element: expected %0d, actual %0d",
                           $signed(oldest_result.element), $signed(m_axis_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[32 +: POS_W+1] !== oldest_result.found_at)
                begin
                    $error("found_at: expected %0d, actual %0d",
                           $signed(oldest_result.found_at),
                           $signed(m_axis_tdata[32 +: POS_W+1]));
                    mismatch_count++;
                end
                if (m_axis_tdata[33+POS_W +: POS_W] !== oldest_result.count)
                begin
                    $error("count: expected %0d, actual %0d",
                           oldest_result.count, m_axis_tdata[33+POS_W +: POS_W]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_edit_and_read();
        test_full_list();
        test_random_walk(600);
        no_idle = 1'b1;
        test_random_walk(300);
        no_idle = 1'b0;
        test_random_walk(300);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ positional_array_list.f @@
rtl/core/pla_pkg.sv
rtl/core/pla_ram.sv
rtl/core/pla_ctrl.sv
rtl/core/pla_datapath.sv
rtl/core/positional_array_list.sv
tb/sv/positional_array_list_tb.sv
